FILE: hdl/assert_macros.svh
// Assertion macros shared by the move-to-front coder RTL.
// Clocked on clk and disabled while arst_n is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge out of reset.
`define MTFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication checked in the same cycle.
`define MTFC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hdl/mtfc_pkg.sv
// Types and constants of the move-to-front coder.
// Used by mtfc_link_mem, move_to_front_codec_core and the testbench; no dependencies.
package mtfc_pkg;

	localparam int SYM_W = 8;
	localparam int SYM_N = 1 << SYM_W;
	localparam int LEN_W = SYM_W + 1;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_ENC  = 2'd1;
	localparam logic [1:0] MODE_DEC  = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_SYM  = 2'd1;
	localparam logic [1:0] STAT_BAD_POS = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FRONT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             en;
		logic [SYM_W-1:0] addr;
		logic [SYM_W-1:0] data;
	} link_wr_t;

endpackage

FILE: hdl/mtfc_link_mem.sv
// Successor memory of the recency list: one write port, one registered read port.
// Depends on mtfc_pkg.
module mtfc_link_mem
	import mtfc_pkg::*;
(
	input  logic             clk,
	input  link_wr_t         wr,
	input  logic [SYM_W-1:0] rd_addr,
	output logic [SYM_W-1:0] rd_data
);

	logic [SYM_W-1:0] mem [SYM_N];
	logic [SYM_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hdl/move_to_front_codec_core.sv
// Byte move-to-front coder: sequencer, list registers and membership map.
// Depends on mtfc_pkg, mtfc_link_mem and assert_macros.svh.
//
// A load item is taken in ST_IDLE and needs no further state. An encode or decode
// item passes ST_IDLE (accept), ST_WALK (walk from the head to its position), ST_FRONT
// (relink to the front) and ST_EMIT (result); ST_FRONT is skipped when the symbol is at
// the front, and an error result goes from ST_IDLE straight to ST_EMIT. The walk along
// the linked recency list reads one successor per cycle through the single read port of
// the successor memory.
// The input side is ready only between items; a waiting result sits in the
// output register and does not hold back the next item until the next result.
`include "assert_macros.svh"

module move_to_front_codec_core
	import mtfc_pkg::*;
#(
	parameter int ALPHABET = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] value
	input  logic [2:0] s_axis_tuser,  // [1:0] mode, [2] first
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] value_res
	output logic [1:0] m_axis_tuser,  // [1:0] status
	output logic       m_axis_tlast
);

	localparam logic [LEN_W-1:0] ALPHA_LEN = LEN_W'(ALPHABET);

	state_t state_q, state_d;

	logic [SYM_W-1:0] head_q, tail_q;
	logic [LEN_W-1:0] len_q;
	logic [SYM_N-1:0] member_q;

	logic [SYM_W-1:0] cur_q, prev_q, pos_q, tgt_q, res_q;
	logic [1:0]       stat_q;
	logic             enc_q, last_q;

	logic             m_tvalid_q, m_tlast_q;
	logic [7:0]       m_tdata_q;
	logic [1:0]       m_tuser_q;

	link_wr_t         mem_wr;
	logic [SYM_W-1:0] rd_addr, rd_data;

	logic             in_acc, in_first, load_add, is_member, walk_done, slot_free;
	logic [1:0]       in_mode;
	logic [SYM_W-1:0] in_val;
	logic [LEN_W-1:0] len_eff;
	logic [SYM_N-1:0] map_eff;

	mtfc_link_mem u_link_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_mode   = s_axis_tuser[1:0];
	assign in_first  = s_axis_tuser[2];
	assign in_val    = s_axis_tdata;
	assign in_acc    = s_axis_tvalid && (state_q == ST_IDLE);
	assign len_eff   = in_first ? '0 : len_q;
	assign map_eff   = in_first ? '0 : member_q;
	assign load_add  = !map_eff[in_val] && (len_eff < ALPHA_LEN);
	assign is_member = member_q[in_val] && (len_q != '0);
	assign slot_free = !m_tvalid_q || m_axis_tready;
	assign walk_done = enc_q ?
		((cur_q == tgt_q) || ({1'b0, pos_q} + LEN_W'(1) >= len_q)) :
		(pos_q == tgt_q);

	always_comb begin
		state_d = state_q;
		mem_wr  = '0;
		rd_addr = cur_q;
		case (state_q)
			ST_IDLE: begin
				rd_addr = head_q;
				if (in_acc) begin
					case (in_mode)
						MODE_LOAD: begin
							if (load_add && (len_eff != '0)) begin
								mem_wr = '{en: 1'b1, addr: tail_q, data: in_val};
							end
						end
						MODE_ENC: begin
							state_d = is_member ? ST_WALK : ST_EMIT;
						end
						MODE_DEC: begin
							state_d = ({1'b0, in_val} < len_q) ? ST_WALK : ST_EMIT;
						end
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				if (walk_done) begin
					if (pos_q != '0) begin
						mem_wr  = '{en: 1'b1, addr: prev_q, data: rd_data};
						state_d = ST_FRONT;
					end else begin
						state_d = ST_EMIT;
					end
				end else begin
					rd_addr = rd_data;
				end
			end
			ST_FRONT: begin
				mem_wr  = '{en: 1'b1, addr: cur_q, data: head_q};
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			len_q      <= '0;
			member_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && (in_mode == MODE_LOAD)) begin
				member_q <= map_eff;
				len_q    <= len_eff;
				if (load_add) begin
					member_q[in_val] <= 1'b1;
					len_q            <= len_eff + LEN_W'(1);
					tail_q           <= in_val;
					if (len_eff == '0) begin
						head_q <= in_val;
					end
				end
			end
			if (state_q == ST_FRONT) begin
				head_q <= cur_q;
				if (cur_q == tail_q) begin
					tail_q <= prev_q;
				end
			end
			if ((state_q == ST_EMIT) && slot_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					tgt_q  <= in_val;
					enc_q  <= (in_mode == MODE_ENC);
					last_q <= s_axis_tlast;
					cur_q  <= head_q;
					prev_q <= head_q;
					pos_q  <= '0;
					res_q  <= '0;
					if (in_mode == MODE_ENC) begin
						stat_q <= is_member ? STAT_OK : STAT_NO_SYM;
					end else begin
						stat_q <= ({1'b0, in_val} < len_q) ? STAT_OK : STAT_BAD_POS;
					end
				end
			end
			ST_WALK: begin
				if (walk_done) begin
					res_q <= enc_q ? pos_q : cur_q;
				end else begin
					prev_q <= cur_q;
					cur_q  <= rd_data;
					pos_q  <= pos_q + SYM_W'(1);
				end
			end
			default: ;
		endcase
		if ((state_q == ST_EMIT) && slot_free) begin
			m_tdata_q <= res_q;
			m_tuser_q <= stat_q;
			m_tlast_q <= last_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;
	assign m_axis_tlast  = m_tlast_q;

	`MTFC_ASSERT(a_len_bound, len_q <= ALPHA_LEN, "list length past alphabet size")
	`MTFC_ASSERT(a_map_count, $countones(member_q) == int'(len_q), "map count off list length")
	`MTFC_ASSERT_IMP(a_walk_in_list, state_q == ST_WALK, ({1'b0, pos_q} < len_q), "walk overrun")
	`MTFC_ASSERT_IMP(a_front_distinct, state_q == ST_FRONT, cur_q != prev_q, "self relink")

endmodule

FILE: sim/move_to_front_codec_core_tb.sv
// Self-checking testbench for move_to_front_codec_core: a scoreboard class predicts
// every result from accepted items; tasks drive the input, an always block the ready.
// Depends on mtfc_pkg and the RTL of the coder.
module move_to_front_codec_core_tb;
	import mtfc_pkg::*;

	localparam int ALPHABET    = 256;
	localparam int HOLD_CYCLES = 1500;
	localparam int WDOG_LIMIT  = 20000;
	localparam int PHASE_ITEMS = 460;

	typedef struct packed {
		logic [7:0] value;
		logic [1:0] status;
		logic       last;
	} mtf_result_t;

	class mtf_scoreboard;
		logic [7:0]       succ[SYM_N];
		logic [7:0]       head_sym;
		logic [7:0]       tail_sym;
		logic [LEN_W-1:0] list_len;
		bit               listed[SYM_N];
		mtf_result_t      pending_q[$];
		int               errors;

		function new();
			foreach (succ[i]) succ[i] = 8'd0;
			foreach (listed[i]) listed[i] = 1'b0;
			head_sym = 8'd0;
			tail_sym = 8'd0;
			list_len = '0;
			errors = 0;
		endfunction

		function void move_front(logic [7:0] sym, logic [7:0] prev);
			succ[prev] = succ[sym];
			if (sym == tail_sym)
				tail_sym = prev;
			succ[sym] = head_sym;
			head_sym = sym;
		endfunction

		function void note_item(logic [1:0] mode, logic [7:0] value, logic first, logic last);
			mtf_result_t res;
			logic [7:0]  cur;
			logic [7:0]  prev;
			int          pos;
			res.value = 8'd0;
			res.status = STAT_OK;
			res.last = last;
			case (mode)
				MODE_LOAD: begin
					if (first) begin
						foreach (listed[i]) listed[i] = 1'b0;
						list_len = '0;
					end
					if (!listed[value] && list_len < ALPHABET) begin
						if (list_len == 0)
							head_sym = value;
						else
							succ[tail_sym] = value;
						tail_sym = value;
						listed[value] = 1'b1;
						list_len++;
					end
					return;
				end
				MODE_ENC: begin
					if (!listed[value] || list_len == 0) begin
						res.status = STAT_NO_SYM;
					end else begin
						cur = head_sym;
						prev = head_sym;
						pos = 0;
						while (cur != value && pos + 1 < list_len) begin
							prev = cur;
							cur = succ[cur];
							pos++;
						end
						res.value = pos[7:0];
						if (pos != 0)
							move_front(cur, prev);
					end
				end
				MODE_DEC: begin
					if ({1'b0, value} >= list_len) begin
						res.status = STAT_BAD_POS;
					end else begin
						cur = head_sym;
						prev = head_sym;
						for (pos = 0; pos < value; pos++) begin
							prev = cur;
							cur = succ[cur];
						end
						res.value = cur;
						if (value != 0)
							move_front(cur, prev);
					end
				end
				default: return;
			endcase
			pending_q.push_back(res);
		endfunction

		function void check_result(logic [7:0] value, logic [1:0] status, logic last);
			mtf_result_t exp_res;
			if (pending_q.size() == 0) begin
				$error("result with none pending: value_res %0d status %0d last_res %0d",
					value, status, last);
				errors++;
				return;
			end
			exp_res = pending_q.pop_front();
			if (value !== exp_res.value) begin
				$error("value_res: expected %0d, got %0d", exp_res.value, value);
				errors++;
			end
			if (status !== exp_res.status) begin
				$error("status: expected %0d, got %0d", exp_res.status, status);
				errors++;
			end
			if (last !== exp_res.last) begin
				$error("last_res: expected %0d, got %0d", exp_res.last, last);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_tdata = 8'd0;
	logic [2:0] s_tuser = 3'd0;
	logic       s_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int wdog_cnt = 0;
	int sent_cnt = 0;

	mtf_scoreboard board = new();

	move_to_front_codec_core #(
		.ALPHABET(ALPHABET)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_tready)
			board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
			wdog_cnt = 0;
		else if (arst_n)
			wdog_cnt++;
		if (wdog_cnt >= WDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] mode, input logic [7:0] value,
			input logic first, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= {first, mode};
		s_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sent_cnt++;
		board.note_item(mode, value, first, last);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (board.pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_block(input int blk);
		int         size;
		int         run_len;
		int         r;
		int         j;
		logic [7:0] tmp;
		logic [7:0] sym;
		logic       lst;
		logic       fst;
		logic [7:0] perm[SYM_N];
		bit         in_set[SYM_N];
		logic [7:0] syms[$];
		foreach (in_set[i]) in_set[i] = 1'b0;
		if (blk % 25 == 3)
			size = ALPHABET;
		else if ($urandom_range(9) == 0)
			size = $urandom_range(64, 17);
		else
			size = $urandom_range(16, 2);
		if (size == ALPHABET) begin
			foreach (perm[i]) perm[i] = i[7:0];
			for (int i = SYM_N - 1; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = perm[i];
				perm[i] = perm[j];
				perm[j] = tmp;
			end
			foreach (perm[i]) begin
				send_item(MODE_LOAD, perm[i], i == 0, 1'($urandom_range(1)));
				syms.push_back(perm[i]);
			end
			send_item(MODE_LOAD, perm[$urandom_range(SYM_N - 1)], 1'b0, 1'b0);
		end else begin
			while (syms.size() < size) begin
				if (syms.size() > 0 && $urandom_range(7) == 0)
					sym = syms[$urandom_range(syms.size() - 1)];
				else
					sym = 8'($urandom_range(255));
				send_item(MODE_LOAD, sym, syms.size() == 0, 1'($urandom_range(1)));
				if (!in_set[sym]) begin
					in_set[sym] = 1'b1;
					syms.push_back(sym);
				end
			end
		end
		if (blk == 2) begin
			run_len = 40;
			hold_seq <= hold_seq + 1;
		end else if (size == ALPHABET) begin
			run_len = 30;
		end else begin
			run_len = $urandom_range(40, 4);
		end
		for (int i = 0; i < run_len; i++) begin
			lst = (i == run_len - 1) || ($urandom_range(15) == 0);
			fst = ($urandom_range(7) == 0);
			r = $urandom_range(99);
			if (r < 45) begin
				send_item(MODE_ENC, syms[$urandom_range(syms.size() - 1)], fst, lst);
			end else if (r < 85) begin
				send_item(MODE_DEC, 8'($urandom_range(syms.size() - 1)), fst, lst);
			end else if (r < 89) begin
				send_item(MODE_ENC, 8'($urandom_range(255)), fst, lst);
			end else if (r < 93) begin
				if (syms.size() < 256)
					send_item(MODE_DEC, 8'($urandom_range(255, syms.size())), fst, lst);
				else
					send_item(MODE_DEC, 8'($urandom_range(255)), fst, lst);
			end else if (r < 96) begin
				send_item(MODE_RSVD, 8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end else if (r < 98) begin
				sym = 8'($urandom_range(255));
				send_item(MODE_LOAD, sym, 1'b0, lst);
				if (!in_set[sym] && syms.size() < ALPHABET) begin
					in_set[sym] = 1'b1;
					syms.push_back(sym);
				end
			end else begin
				send_item($urandom_range(1) ? MODE_ENC : MODE_DEC,
					syms[$urandom_range(syms.size() - 1)], 1'b1, lst);
			end
		end
	endtask

	initial begin
		int blk;
		int phase_start;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(MODE_ENC, 8'h00, 1'b0, 1'b0);
		send_item(MODE_DEC, 8'h00, 1'b0, 1'b1);
		send_item(MODE_RSVD, 8'hFF, 1'b1, 1'b1);
		send_item(MODE_LOAD, 8'h00, 1'b1, 1'b0);
		send_item(MODE_LOAD, 8'hFF, 1'b0, 1'b0);
		send_item(MODE_LOAD, 8'hFF, 1'b0, 1'b1);
		send_item(MODE_LOAD, 8'hA5, 1'b0, 1'b0);
		send_item(MODE_LOAD, 8'h5A, 1'b0, 1'b0);
		send_item(MODE_ENC, 8'hFF, 1'b0, 1'b0);
		send_item(MODE_ENC, 8'hFF, 1'b0, 1'b0);
		send_item(MODE_ENC, 8'h5A, 1'b0, 1'b1);
		send_item(MODE_ENC, 8'h33, 1'b0, 1'b0);
		send_item(MODE_DEC, 8'h03, 1'b0, 1'b0);
		send_item(MODE_DEC, 8'h00, 1'b0, 1'b0);
		send_item(MODE_DEC, 8'h04, 1'b0, 1'b0);
		send_item(MODE_DEC, 8'hFF, 1'b0, 1'b1);
		send_item(MODE_ENC, 8'h00, 1'b1, 1'b0);
		send_item(MODE_LOAD, 8'h77, 1'b1, 1'b0);
		send_item(MODE_ENC, 8'h77, 1'b0, 1'b0);
		send_item(MODE_DEC, 8'h00, 1'b0, 1'b0);
		send_item(MODE_DEC, 8'h01, 1'b0, 1'b0);
		send_item(MODE_ENC, 8'h00, 1'b0, 1'b1);
		drain_results();

		blk = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					sender_idle_pct = 80;
					recv_stall_pct <= 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct <= 80;
				end
				default: begin
					sender_idle_pct = 30;
					recv_stall_pct <= 30;
				end
			endcase
			phase_start = sent_cnt;
			while (sent_cnt - phase_start < PHASE_ITEMS) begin
				run_block(blk);
				blk++;
			end
			drain_results();
		end

		repeat (300) @(posedge clk);
		if (board.errors == 0 && board.pending_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/mtfc_pkg.sv
hdl/mtfc_link_mem.sv
hdl/move_to_front_codec_core.sv
sim/move_to_front_codec_core_tb.sv
